>>> design/dst_pkg.sv
// shared types, constants and tables for the eu dst offset pipeline
package dst_pkg;

    // field widths
    localparam int UTC_W  = 32;
    localparam int OFS_W  = 16;
    localparam int DAYS_W = 16;
    localparam int DOE_W  = 18;
    localparam int DOY_W  = 9;
    localparam int YOE_W  = 9;
    localparam int WDAY_W = 3;
    localparam int MP_W   = 4;
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    // register reset values
    localparam logic [OFS_W-1:0] STD_OFS_RST = 16'd3600;
    localparam logic [OFS_W-1:0] SUM_OFS_RST = 16'd7200;

    // register index, taken from paddr[2]
    localparam logic CFG_STANDARD = 1'b0;
    localparam logic CFG_SUMMER   = 1'b1;

    // seconds to days: (t >> 7) / 675 by reciprocal multiply
    localparam int               SEC_PRE_SHIFT = 7;
    localparam logic [25:0]      RECIP_675     = 26'd50903317;
    localparam logic [31:0]      SECS_PER_DAY  = 32'd86400;
    localparam logic [16:0]      SECS_PER_HOUR = 17'd3600;

    // day count to era-relative day
    localparam logic [19:0] EPOCH_SHIFT = 20'd719468;
    localparam logic [19:0] ERA4_BASE   = 20'd584388;
    localparam logic [19:0] ERA5_BASE   = 20'd730485;
    localparam logic [15:0] WDAY_SHIFT  = 16'd4;

    // day of era corrections
    localparam logic [16:0]      RECIP_1460_Q = 17'd91930;   // (doe >> 2) / 365, shift 25
    localparam logic [18:0]      RECIP_365    = 19'd367720;  // num / 365, shift 27
    localparam logic [DOE_W-1:0] CENT_1       = 18'd36524;
    localparam logic [DOE_W-1:0] CENT_2       = 18'd73048;
    localparam logic [DOE_W-1:0] CENT_3       = 18'd109572;
    localparam logic [DOE_W-1:0] CENT_4       = 18'd146096;
    localparam logic [YOE_W-1:0] YEARS_100    = 9'd100;
    localparam logic [YOE_W-1:0] YEARS_200    = 9'd200;
    localparam logic [YOE_W-1:0] YEARS_300    = 9'd300;
    localparam logic [DOE_W-1:0] DAYS_PER_YR  = 18'd365;

    // months counted from march
    localparam logic [MP_W-1:0] MP_MARCH   = 4'd0;
    localparam logic [MP_W-1:0] MP_OCTOBER = 4'd7;
    localparam int              MP_LAST    = 11;
    localparam logic [DOY_W-1:0] LAST_SUN_MIN = 9'd25;

    // per-item sideband carried down the pipe
    typedef struct packed {
        logic [WDAY_W-1:0] wday;
        logic              hour_ge1;
    } side_t;

    // stage load enables
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
        logic s5;
    } pipe_en_t;

    // first day of year (from march) of each month
    function automatic logic [DOY_W-1:0] month_start(input logic [MP_W-1:0] mp);
        logic [DOY_W-1:0] d;
        case (mp)
            4'd0:    d = 9'd0;
            4'd1:    d = 9'd31;
            4'd2:    d = 9'd61;
            4'd3:    d = 9'd92;
            4'd4:    d = 9'd122;
            4'd5:    d = 9'd153;
            4'd6:    d = 9'd184;
            4'd7:    d = 9'd214;
            4'd8:    d = 9'd245;
            4'd9:    d = 9'd275;
            4'd10:   d = 9'd306;
            4'd11:   d = 9'd337;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

endpackage

>>> design/dst_ifs.sv
// valid/ready channel interfaces for timestamp input and offset output
interface dst_in_if;
    import dst_pkg::*;
    logic             valid;
    logic             ready;
    logic [UTC_W-1:0] utc_seconds;

    modport source (output valid, output utc_seconds, input ready);
    modport sink (input valid, input utc_seconds, output ready);
endinterface

interface dst_out_if;
    import dst_pkg::*;
    logic             valid;
    logic             ready;
    logic [OFS_W-1:0] offset_seconds;
    logic             summer_active;

    modport source (output valid, output offset_seconds, output summer_active, input ready);
    modport sink (input valid, input offset_seconds, input summer_active, output ready);
endinterface

>>> design/dst_days.sv
// stages 1-2: seconds to day count, hour flag, weekday and day of era
module dst_days (
    input  logic                        clk,
    input  logic [dst_pkg::UTC_W-1:0]   t_in,
    input  dst_pkg::pipe_en_t           en,
    output logic [dst_pkg::DOE_W-1:0]   doe,
    output dst_pkg::side_t              side
);
    import dst_pkg::*;

    logic [UTC_W-1:0]  t1_reg;
    logic [50:0]       prod1_reg;
    logic [50:0]       prod1_next;
    logic [DOE_W-1:0]  doe_reg;
    logic [DOE_W-1:0]  doe_next;
    side_t             side_reg;
    side_t             side_next;

    logic [DAYS_W-1:0] days;
    logic [UTC_W-1:0]  day_secs;
    logic [UTC_W-1:0]  sod;
    logic [16:0]       wsum;
    logic [17:0]       wpad;
    logic [5:0]        fold1;
    logic [3:0]        fold2;
    logic [19:0]       z;
    logic [19:0]       doe_w;

    // reciprocal multiply for the day count
    always_comb
    begin
        prod1_next = {26'd0, t_in[UTC_W-1:SEC_PRE_SHIFT]} * {25'd0, RECIP_675};
    end

    // day split, weekday by base-8 digit folding, era offset
    always_comb
    begin
        days     = prod1_reg[50:35];
        day_secs = {16'd0, days} * SECS_PER_DAY;
        sod      = t1_reg - day_secs;

        wsum  = {1'b0, days} + {1'b0, WDAY_SHIFT};
        wpad  = {1'b0, wsum};
        fold1 = {3'd0, wpad[2:0]} + {3'd0, wpad[5:3]} + {3'd0, wpad[8:6]}
              + {3'd0, wpad[11:9]} + {3'd0, wpad[14:12]} + {3'd0, wpad[17:15]};
        fold2 = {1'b0, fold1[5:3]} + {1'b0, fold1[2:0]};
        if (fold2 >= 4'd7)
        begin
            fold2 = fold2 - 4'd7;
        end
        side_next.wday     = fold2[2:0];
        side_next.hour_ge1 = (sod[16:0] >= SECS_PER_HOUR);

        z = {4'd0, days} + EPOCH_SHIFT;
        if (z >= ERA5_BASE)
        begin
            doe_w = z - ERA5_BASE;
        end
        else
        begin
            doe_w = z - ERA4_BASE;
        end
        doe_next = doe_w[DOE_W-1:0];
    end

    // pipeline registers
    always_ff @(posedge clk)
    begin
        if (en.s1)
        begin
            t1_reg    <= t_in;
            prod1_reg <= prod1_next;
        end
        if (en.s2)
        begin
            doe_reg  <= doe_next;
            side_reg <= side_next;
        end
    end

    assign doe  = doe_reg;
    assign side = side_reg;

endmodule

>>> design/dst_civil.sv
// stages 3-5: day of era to year of era and day of year
module dst_civil (
    input  logic                        clk,
    input  logic [dst_pkg::DOE_W-1:0]   doe,
    input  dst_pkg::side_t              side_in,
    input  dst_pkg::pipe_en_t           en,
    output logic [dst_pkg::DOY_W-1:0]   doy,
    output dst_pkg::side_t              side
);
    import dst_pkg::*;

    logic [32:0]      prod2_reg;
    logic [32:0]      prod2_next;
    logic [2:0]       cent_reg;
    logic [2:0]       cent_next;
    logic             last_reg;
    logic [DOE_W-1:0] doe3_reg;
    side_t            side3_reg;

    logic [35:0]      prod4_reg;
    logic [35:0]      prod4_next;
    logic [DOE_W-1:0] doe4_reg;
    side_t            side4_reg;

    logic [DOY_W-1:0] doy_reg;
    logic [DOY_W-1:0] doy_next;
    side_t            side5_reg;

    logic [7:0]       q1460;
    logic [DOE_W-1:0] num;
    logic [YOE_W-1:0] yoe;
    logic [1:0]       c100;
    logic [DOE_W-1:0] base;

    // stage 3: doe / 1460 multiply, century count
    always_comb
    begin
        prod2_next = {17'd0, doe[DOE_W-1:2]} * {16'd0, RECIP_1460_Q};
        if (doe >= CENT_4)
        begin
            cent_next = 3'd4;
        end
        else if (doe >= CENT_3)
        begin
            cent_next = 3'd3;
        end
        else if (doe >= CENT_2)
        begin
            cent_next = 3'd2;
        end
        else if (doe >= CENT_1)
        begin
            cent_next = 3'd1;
        end
        else
        begin
            cent_next = 3'd0;
        end
    end

    // stage 4: leap-corrected day count divided by 365
    always_comb
    begin
        q1460 = prod2_reg[32:25];
        num   = doe3_reg - {10'd0, q1460} + {15'd0, cent_reg} - {17'd0, last_reg};
        prod4_next = 36'({19'd0, num} * {18'd0, RECIP_365});
    end

    // stage 5: day of year
    always_comb
    begin
        yoe = prod4_reg[35:27];
        if (yoe >= YEARS_300)
        begin
            c100 = 2'd3;
        end
        else if (yoe >= YEARS_200)
        begin
            c100 = 2'd2;
        end
        else if (yoe >= YEARS_100)
        begin
            c100 = 2'd1;
        end
        else
        begin
            c100 = 2'd0;
        end
        base = 18'({9'd0, yoe} * DAYS_PER_YR) + {11'd0, yoe[YOE_W-1:2]} - {16'd0, c100};
        doy_next = 9'(doe4_reg - base);
    end

    // pipeline registers
    always_ff @(posedge clk)
    begin
        if (en.s3)
        begin
            prod2_reg <= prod2_next;
            cent_reg  <= cent_next;
            last_reg  <= (doe == CENT_4);
            doe3_reg  <= doe;
            side3_reg <= side_in;
        end
        if (en.s4)
        begin
            prod4_reg <= prod4_next;
            doe4_reg  <= doe3_reg;
            side4_reg <= side3_reg;
        end
        if (en.s5)
        begin
            doy_reg   <= doy_next;
            side5_reg <= side4_reg;
        end
    end

    assign doy  = doy_reg;
    assign side = side5_reg;

endmodule

>>> design/dst_rule.sv
// month, day of month and the european summer time decision
module dst_rule (
    input  logic [dst_pkg::DOY_W-1:0] doy,
    input  dst_pkg::side_t            side,
    output logic                      summer
);
    import dst_pkg::*;

    logic [MP_W-1:0]  mp;
    logic [DOY_W-1:0] mday;
    logic [DOY_W-1:0] limit;
    logic             past_last_sun;

    // month from march, day of month
    always_comb
    begin
        mp = MP_MARCH;
        for (int k = 1; k <= MP_LAST; k++)
        begin
            if (doy >= month_start(4'(k)))
            begin
                mp = 4'(k);
            end
        end
        mday = doy - month_start(mp) + 9'd1;
    end

    // on or after the last sunday, 01:00 utc on the sunday itself
    always_comb
    begin
        limit = LAST_SUN_MIN + {6'd0, side.wday};
        past_last_sun = (mday >= limit) && ((side.wday != 3'd0) || side.hour_ge1);
        case (mp)
            MP_MARCH:   summer = past_last_sun;
            MP_OCTOBER: summer = !past_last_sun;
            default:    summer = (mp > MP_MARCH) && (mp < MP_OCTOBER);
        endcase
    end

endmodule

>>> design/eu_dst_offset_from_epoch_top.sv
// top level: input stage, date pipeline, offset registers and result register
// a result passes the input register, the date stages and the result register in turn
// throughput: one transaction per cycle unless stalled; the constant-divisor multiply stages set the depth
// stalled results hold in place while empty stages still take new transactions
// reset: asynchronous, clears all valid bits, offsets return to 3600 and 7200
module eu_dst_offset_from_epoch_top (
    input  logic                         clk,
    input  logic                         rst_n,
    dst_in_if.sink                       in_ch,
    dst_out_if.source                    out_ch,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [dst_pkg::APB_AW-1:0]   paddr,
    input  logic [dst_pkg::APB_DW-1:0]   pwdata,
    output logic [dst_pkg::APB_DW-1:0]   prdata,
    output logic                         pready
);
    import dst_pkg::*;

    logic [OFS_W-1:0] std_ofs_reg;
    logic [OFS_W-1:0] sum_ofs_reg;

    logic [UTC_W-1:0] t0_reg;
    logic             v0_reg;
    logic             v1_reg;
    logic             v2_reg;
    logic             v3_reg;
    logic             v4_reg;
    logic             v5_reg;
    logic             out_valid_reg;
    logic [OFS_W-1:0] offset_reg;
    logic             summer_reg;

    logic             en0;
    logic             en_out;
    pipe_en_t         en;
    logic             cfg_wr;

    logic [DOE_W-1:0] doe;
    side_t            side2;
    logic [DOY_W-1:0] doy;
    side_t            side5;
    logic             summer;

    // stage load enables, a stage loads when empty or draining
    always_comb
    begin
        en_out = !out_valid_reg || out_ch.ready;
        en.s5  = !v5_reg || en_out;
        en.s4  = !v4_reg || en.s5;
        en.s3  = !v3_reg || en.s4;
        en.s2  = !v2_reg || en.s3;
        en.s1  = !v1_reg || en.s2;
        en0    = !v0_reg || en.s1;
    end

    assign in_ch.ready = en0;
    assign cfg_wr      = psel && penable && pwrite && pready;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            std_ofs_reg <= STD_OFS_RST;
            sum_ofs_reg <= SUM_OFS_RST;
        end
        else if (cfg_wr)
        begin
            case (paddr[2])
                CFG_STANDARD: std_ofs_reg <= pwdata[OFS_W-1:0];
                CFG_SUMMER:   sum_ofs_reg <= pwdata[OFS_W-1:0];
                default:      std_ofs_reg <= std_ofs_reg;
            endcase
        end
    end

    // register readback
    always_comb
    begin
        case (paddr[2])
            CFG_STANDARD: prdata = {16'd0, std_ofs_reg};
            CFG_SUMMER:   prdata = {16'd0, sum_ofs_reg};
            default:      prdata = '0;
        endcase
    end

    assign pready = 1'b1;

    // stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg        <= 1'b0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            v5_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (en0)
            begin
                v0_reg <= in_ch.valid;
            end
            if (en.s1)
            begin
                v1_reg <= v0_reg;
            end
            if (en.s2)
            begin
                v2_reg <= v1_reg;
            end
            if (en.s3)
            begin
                v3_reg <= v2_reg;
            end
            if (en.s4)
            begin
                v4_reg <= v3_reg;
            end
            if (en.s5)
            begin
                v5_reg <= v4_reg;
            end
            if (en_out)
            begin
                out_valid_reg <= v5_reg;
            end
        end
    end

    // input and result payload
    always_ff @(posedge clk)
    begin
        if (en0)
        begin
            t0_reg <= in_ch.utc_seconds;
        end
        if (en_out)
        begin
            summer_reg <= summer;
            offset_reg <= summer ? sum_ofs_reg : std_ofs_reg;
        end
    end

    dst_days u_days (
        .clk  (clk),
        .t_in (t0_reg),
        .en   (en),
        .doe  (doe),
        .side (side2)
    );

    dst_civil u_civil (
        .clk     (clk),
        .doe     (doe),
        .side_in (side2),
        .en      (en),
        .doy     (doy),
        .side    (side5)
    );

    dst_rule u_rule (
        .doy    (doy),
        .side   (side5),
        .summer (summer)
    );

    assign out_ch.valid          = out_valid_reg;
    assign out_ch.offset_seconds = offset_reg;
    assign out_ch.summer_active  = summer_reg;

endmodule

>>> design/dst_checker.sv
// port-level checker for the dst offset block, bound to the top level
module dst_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_valid,
    input logic                       in_ready,
    input logic                       out_valid,
    input logic                       out_ready,
    input logic                       psel,
    input logic                       penable,
    input logic                       pwrite,
    input logic                       pready,
    input logic [dst_pkg::APB_AW-1:0] paddr,
    input logic [dst_pkg::APB_DW-1:0] pwdata,
    input logic [dst_pkg::APB_DW-1:0] prdata
);
    import dst_pkg::*;

    localparam logic [3:0] PIPE_SLOTS = 4'd7;

    logic [3:0]       pend_reg;
    logic [3:0]       pend_next;
    logic [OFS_W-1:0] sh_std_reg;
    logic [OFS_W-1:0] sh_sum_reg;
    logic             in_acc;
    logic             out_acc;

    // transactions in flight
    always_comb
    begin
        in_acc    = in_valid && in_ready;
        out_acc   = out_valid && out_ready;
        pend_next = pend_reg + {3'd0, in_acc} - {3'd0, out_acc};
    end

    // shadow of the offset registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg   <= 4'd0;
            sh_std_reg <= STD_OFS_RST;
            sh_sum_reg <= SUM_OFS_RST;
        end
        else
        begin
            pend_reg <= pend_next;
            if (psel && penable && pwrite && pready)
            begin
                if (paddr[2] == CFG_SUMMER)
                begin
                    sh_sum_reg <= pwdata[OFS_W-1:0];
                end
                else
                begin
                    sh_std_reg <= pwdata[OFS_W-1:0];
                end
            end
        end
    end

    // a result holds until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped before it was taken");

    // no result without an accepted input behind it
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pend_reg != 4'd0)
        else $error("result with no transaction in flight");

    // the pipe never holds more than its slots
    a_capacity: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg <= PIPE_SLOTS)
        else $error("more transactions in flight than pipeline slots");

    // an empty output stage never blocks the input
    a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled while output stage is empty");

    // readback matches the last written value
    a_readback: assert property (@(posedge clk) disable iff (!rst_n)
        psel && !pwrite |-> prdata == ((paddr[2] == CFG_SUMMER) ? {16'd0, sh_sum_reg}
                                                             : {16'd0, sh_std_reg}))
        else $error("register readback mismatch");

endmodule

bind eu_dst_offset_from_epoch_top dst_checker u_dst_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .pready    (pready),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata)
);
